// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRIO_W   = 2;
    localparam int TAG_IN_W = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [PRIO_W-1:0] prio;
    } cell_ctl_t;

endpackage

// ===== rtl/core/stable_priority_ring_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_priority_ring_queue_unit
// Bounded queue kept in priority order, equal priorities in arrival order.
// ----------------------------------------------------------------------------
// Input words on s_*: s_tuser selects push or pop, s_tdata carries the
// priority and tag of a push. Each input word yields one output word on m_*:
// status in m_tuser, popped tag and priority (zero unless a pop succeeds) and
// the occupancy after the operation in m_tdata.
// The queue is a row of DEPTH cells, head in cell 0. On a push every cell
// compares its priority with the new one in parallel and the cells behind the
// insertion point shift one place back; on a pop all cells shift forward.
// m_tvalid rises in the cycle after acceptance. One word is taken every
// cycle; the output register is refilled in the cycle it is read, so the
// input stalls only while a result waits and m_tready is low.
// A push on a full queue is dropped with status full; a pop on an empty
// queue leaves it unchanged with status empty.
// Reset empties the queue and clears m_tvalid; the output data are not reset.
// ----------------------------------------------------------------------------
module stable_priority_ring_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH           = 16,
    parameter int PRIORITY_LEVELS = 4,
    parameter int TAG_WIDTH       = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // item_priority[1:0], item_tag[17:2]
    input  logic [0:0]           s_tuser,   // func[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // head_tag, head_priority, occupancy
    output logic [((TAG_IN_W + PRIO_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser    // status[1:0]
);

    localparam int OCC_W    = $clog2(DEPTH + 1);
    localparam int TW       = (TAG_WIDTH < TAG_IN_W) ? TAG_WIDTH : TAG_IN_W;
    localparam int M_BITS   = TAG_IN_W + PRIO_W + OCC_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    logic [OCC_W-1:0]  count_reg, count_next;
    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [STATUS_W-1:0] m_user_reg, m_user_next;

    logic              accept;
    func_t             func;
    logic [PRIO_W-1:0] in_prio, sat_prio;
    logic [TW-1:0]     in_tag;
    logic              full, empty;
    cell_ctl_t         ctl;

    logic [DEPTH-1:0]  after;
    logic [TW-1:0]     tags  [DEPTH];
    logic [PRIO_W-1:0] prios [DEPTH];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser[0]);
    assign in_prio  = s_tdata[PRIO_W-1:0];
    assign in_tag   = s_tdata[PRIO_W +: TW];
    assign sat_prio = (int'(in_prio) > PRIORITY_LEVELS - 1)
                      ? PRIO_W'(PRIORITY_LEVELS - 1) : in_prio;
    assign full     = count_reg == OCC_W'(DEPTH);
    assign empty    = count_reg == '0;

    assign ctl.push = accept && (func == FUNC_PUSH) && !full;
    assign ctl.pop  = accept && (func == FUNC_POP) && !empty;
    assign ctl.prio = sat_prio;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              l_after;
        logic [TW-1:0]     l_tag, r_tag;
        logic [PRIO_W-1:0] l_prio, r_prio;

        if (i == 0) begin : g_head
            assign l_after = 1'b0;
            assign l_tag   = tags[0];
            assign l_prio  = prios[0];
        end else begin : g_body
            assign l_after = after[i-1];
            assign l_tag   = tags[i-1];
            assign l_prio  = prios[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign r_tag  = tags[i];
            assign r_prio = prios[i];
        end else begin : g_inner
            assign r_tag  = tags[i+1];
            assign r_prio = prios[i+1];
        end

        spq_cell #(
            .INDEX (i),
            .OCC_W (OCC_W),
            .TW    (TW)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .count      (count_reg),
            .new_tag    (in_tag),
            .left_after (l_after),
            .left_tag   (l_tag),
            .left_prio  (l_prio),
            .right_tag  (r_tag),
            .right_prio (r_prio),
            .after      (after[i]),
            .tag        (tags[i]),
            .prio       (prios[i])
        );
    end

    always_comb begin
        count_next  = count_reg;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        if (ctl.push) begin
            count_next = count_reg + 1'b1;
        end else if (ctl.pop) begin
            count_next = count_reg - 1'b1;
        end
        if (accept) begin
            m_data_next = '0;
            m_data_next[TAG_IN_W + PRIO_W +: OCC_W] = count_next;
            if (ctl.pop) begin
                m_data_next[TAG_IN_W-1:0]        = TAG_IN_W'(tags[0]);
                m_data_next[TAG_IN_W +: PRIO_W]  = prios[0];
            end
            if (func == FUNC_PUSH) begin
                m_user_next = full ? ST_FULL : ST_OK;
            end else begin
                m_user_next = empty ? ST_EMPTY : ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the ordered queue: holds a tag and a priority, takes the left
// neighbor's entry or the new entry on a push, the right neighbor's on a pop.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int OCC_W = 5,
    parameter int TW    = 16
) (
    input  logic              aclk,
    input  cell_ctl_t         ctl,
    input  logic [OCC_W-1:0]  count,
    input  logic [TW-1:0]     new_tag,
    input  logic              left_after,
    input  logic [TW-1:0]     left_tag,
    input  logic [PRIO_W-1:0] left_prio,
    input  logic [TW-1:0]     right_tag,
    input  logic [PRIO_W-1:0] right_prio,
    output logic              after,
    output logic [TW-1:0]     tag,
    output logic [PRIO_W-1:0] prio
);

    logic [TW-1:0]     tag_reg,  tag_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic              held;

    assign held  = count > OCC_W'(INDEX);
    assign after = !held || (prio_reg > ctl.prio);
    assign tag   = tag_reg;
    assign prio  = prio_reg;

    always_comb begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ctl.push && after) begin
            if (left_after) begin
                tag_next  = left_tag;
                prio_next = left_prio;
            end else begin
                tag_next  = new_tag;
                prio_next = ctl.prio;
            end
        end else if (ctl.pop) begin
            tag_next  = right_tag;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

endmodule
